// ----- design/nalsp_pkg.sv -----
// Shared types and constants for the start-code NAL unit splitter.
`default_nettype none

package nalsp_pkg;

  // NAL header bytes of the unit types that are kept
  localparam logic [7:0] NalSps = 8'h67;
  localparam logic [7:0] NalPps = 8'h68;
  localparam logic [7:0] NalIdr = 8'h65;
  localparam logic [7:0] NalP   = 8'h61;
  localparam logic [7:0] StartCodeTail = 8'h01;

  // unit_kind codes
  localparam logic [1:0] KindSps = 2'd0;
  localparam logic [1:0] KindPps = 2'd1;
  localparam logic [1:0] KindIdr = 2'd2;
  localparam logic [1:0] KindP   = 2'd3;

  // token queue between scanner and emitter
  localparam int TokDepth = 4;
  localparam int TokPtrW  = $clog2(TokDepth);
  localparam int TokCntW  = $clog2(TokDepth + 1);

  typedef enum logic [1:0] {
    ScanSearch,
    ScanKind,
    ScanBody,
    ScanSkip
  } scan_mode_e;

  typedef enum logic [1:0] {
    TokStart,   // prefix, then type byte held or sent at chunk end
    TokBody,    // body byte goes into the delay line
    TokMatch,   // start code found: oldest held byte closes the unit
    TokEnd      // chunk end: flush held bytes, then this byte closes the unit
  } tok_op_e;

  typedef struct packed {
    tok_op_e    op;
    logic [7:0] data;
    logic [1:0] kind;
    logic       chunk_end;
  } tok_t;

  // queue handshake seen by the emitter
  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_head_t;

endpackage

`default_nettype wire

// ----- design/nalsp_front.sv -----
// Scanner: finds start codes, classifies units and issues at most one token per byte.
`default_nettype none

module nalsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           chunk_end_i,
  output logic           tok_push_o,
  output nalsp_pkg::tok_t tok_o
);
  import nalsp_pkg::*;

  scan_mode_e mode_q, mode_d;
  logic [7:0] win_q [2];
  logic [7:0] win_d [2];
  logic [1:0] wcnt_q, wcnt_d;
  logic [1:0] kind_q, kind_d;
  logic       match;
  logic       kind_ok;
  logic [1:0] kind_new;

  always_comb begin
    kind_ok  = 1'b1;
    kind_new = KindSps;
    unique case (in_byte_i)
      NalSps:  kind_new = KindSps;
      NalPps:  kind_new = KindPps;
      NalIdr:  kind_new = KindIdr;
      NalP:    kind_new = KindP;
      default: kind_ok = 1'b0;
    endcase
  end

  assign match = wcnt_q[1] && (win_q[0] == 8'h00) && (win_q[1] == 8'h00) &&
                 (in_byte_i == StartCodeTail);

  always_comb begin
    mode_d         = mode_q;
    win_d          = win_q;
    wcnt_d         = wcnt_q;
    kind_d         = kind_q;
    tok_push_o     = 1'b0;
    tok_o.op       = TokBody;
    tok_o.data     = in_byte_i;
    tok_o.kind     = kind_q;
    tok_o.chunk_end = chunk_end_i;
    if (accept_i) begin
      unique case (mode_q)
        ScanSearch, ScanSkip: begin
          if (match) begin
            mode_d = ScanKind;
            wcnt_d = 2'd0;
          end else begin
            win_d[0] = win_q[1];
            win_d[1] = in_byte_i;
            wcnt_d   = wcnt_q[1] ? 2'd2 : wcnt_q + 2'd1;
          end
        end
        ScanKind: begin
          win_d[0] = win_q[1];
          win_d[1] = in_byte_i;
          wcnt_d   = wcnt_q[1] ? 2'd2 : wcnt_q + 2'd1;
          if (kind_ok) begin
            kind_d     = kind_new;
            tok_push_o = 1'b1;
            tok_o.op   = TokStart;
            tok_o.kind = kind_new;
            mode_d     = ScanBody;
          end else begin
            mode_d = ScanSkip;
          end
        end
        ScanBody: begin
          tok_push_o = 1'b1;
          if (match) begin
            tok_o.op = TokMatch;
            wcnt_d   = 2'd0;
            mode_d   = ScanKind;
          end else if (chunk_end_i) begin
            tok_o.op = TokEnd;
          end else begin
            tok_o.op = TokBody;
            win_d[0] = win_q[1];
            win_d[1] = in_byte_i;
            wcnt_d   = wcnt_q[1] ? 2'd2 : wcnt_q + 2'd1;
          end
        end
        default: mode_d = ScanSearch;
      endcase
      // every chunk starts from scratch
      if (chunk_end_i) begin
        mode_d   = ScanSearch;
        win_d[0] = 8'h00;
        win_d[1] = 8'h00;
        wcnt_d   = 2'd0;
        kind_d   = KindSps;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ScanSearch;
      win_q[0] <= 8'h00;
      win_q[1] <= 8'h00;
      wcnt_q <= 2'd0;
      kind_q <= KindSps;
    end else begin
      mode_q <= mode_d;
      win_q  <= win_d;
      wcnt_q <= wcnt_d;
      kind_q <= kind_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/nalsp_fifo.sv -----
// Short token queue between scanner and emitter.
`default_nettype none

module nalsp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nalsp_pkg::tok_t      tok_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output nalsp_pkg::tok_head_t head_o
);
  import nalsp_pkg::*;

  tok_t               mem_q [TokDepth];
  logic [TokPtrW-1:0] wr_q, rd_q;
  logic [TokCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o      = (cnt_q == TokCntW'(TokDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.tok   = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + TokPtrW'(1);
      if (do_pop)  rd_q <= rd_q + TokPtrW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + TokCntW'(1);
        2'b01:   cnt_q <= cnt_q - TokCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/nalsp_back.sv -----
// Emitter: expands tokens into output words through a three-byte delay line.
`default_nettype none

module nalsp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nalsp_pkg::tok_head_t head_i,
  output logic                 tok_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output logic [7:0]           out_byte_o,
  output logic                 unit_first_o,
  output logic                 unit_last_o,
  output logic [1:0]           unit_kind_o
);
  import nalsp_pkg::*;

  logic [2:0] step_q, step_d;
  logic [7:0] held_q [3];
  logic [7:0] held_d [3];
  logic [1:0] hcnt_q, hcnt_d;
  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       ofirst_q, olast_q;
  logic [1:0] okind_q;

  logic       out_free, go, done, emit;
  logic [7:0] e_byte;
  logic       e_first, e_last;
  tok_t       tok;

  assign tok      = head_i.tok;
  assign out_free = !ovalid_q || pop_i;
  assign go       = head_i.valid && out_free;

  always_comb begin
    step_d  = step_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    done    = 1'b0;
    emit    = 1'b0;
    e_byte  = 8'h00;
    e_first = 1'b0;
    e_last  = 1'b0;
    unique case (tok.op)
      TokStart: begin
        emit    = 1'b1;
        e_first = (step_q == 3'd0);
        if (step_q == 3'd3) e_byte = StartCodeTail;
        if (step_q == 3'd4) begin
          e_byte = tok.data;
          e_last = 1'b1;
        end
        done = tok.chunk_end ? (step_q == 3'd4) : (step_q == 3'd3);
        if (done && !tok.chunk_end) begin
          held_d[0] = tok.data;
          hcnt_d    = 2'd1;
        end
      end
      TokBody: begin
        done = 1'b1;
        if (hcnt_q == 2'd3) begin
          emit      = 1'b1;
          e_byte    = held_q[0];
          held_d[0] = held_q[1];
          held_d[1] = held_q[2];
          held_d[2] = tok.data;
        end else begin
          held_d[hcnt_q] = tok.data;
          hcnt_d         = hcnt_q + 2'd1;
        end
      end
      TokMatch: begin
        done   = 1'b1;
        emit   = (hcnt_q == 2'd3);
        e_byte = held_q[0];
        e_last = 1'b1;
        hcnt_d = 2'd0;
      end
      TokEnd: begin
        emit = 1'b1;
        if (step_q < {1'b0, hcnt_q}) begin
          e_byte = held_q[step_q[1:0]];
        end else begin
          e_byte = tok.data;
          e_last = 1'b1;
          done   = 1'b1;
          hcnt_d = 2'd0;
        end
      end
      default: done = 1'b1;
    endcase
    if (done) step_d = 3'd0;
    else      step_d = step_q + 3'd1;
  end

  assign tok_pop_o = go && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= 3'd0;
      hcnt_q   <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      if (go) begin
        step_q <= step_d;
        hcnt_q <= hcnt_d;
      end
      if (out_free) ovalid_q <= go && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) held_q <= held_d;
    if (out_free) begin
      obyte_q  <= e_byte;
      ofirst_q <= e_first;
      olast_q  <= e_last;
      okind_q  <= tok.kind;
    end
  end

  assign empty_o      = !ovalid_q;
  assign out_byte_o   = obyte_q;
  assign unit_first_o = ofirst_q;
  assign unit_last_o  = olast_q;
  assign unit_kind_o  = okind_q;

  // a token being expanded stays at the queue head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != 3'd0) |-> head_i.valid)
    else $error("token left the queue mid expansion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 3'd4)
    else $error("expansion step out of range");

  // the first prefix word is a zero byte and never closes a unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ofirst_q) |-> (obyte_q == 8'h00) && !olast_q)
    else $error("bad first word of a unit");

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !pop_i) |=> ovalid_q && $stable(obyte_q))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// ----- design/h264_start_code_nal_splitter.sv -----
// Top level of the H.264 byte-stream start-code NAL unit splitter.
//
//  channel  | direction | handshake            | words
//  input    | in        | push / full          | in_byte_i, chunk_end_i
//  result   | out       | empty / pop          | out_byte_o, unit_first_o,
//           |           |                      | unit_last_o, unit_kind_o
//
// One input word is taken per cycle while the token queue has room; the
// scanner issues at most one token per word, so input rate is one a cycle.
// The emitter sends at most one output word per cycle while the output
// register is free: a kept unit adds four prefix words, and a chunk end
// flushes up to three held bytes of the delay line. The output register
// stays full until popped; the queue absorbs a prefix burst. Reset clears
// the scan state, queue and output register.
`default_nettype none

module h264_start_code_nal_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       chunk_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       unit_first_o,
  output logic       unit_last_o,
  output logic [1:0] unit_kind_o
);
  import nalsp_pkg::*;

  logic      accept;
  logic      tok_push;
  tok_t      tok;
  tok_head_t head;
  logic      tok_pop;

  assign accept = push && !full;

  nalsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .chunk_end_i (chunk_end_i),
    .tok_push_o  (tok_push),
    .tok_o       (tok)
  );

  nalsp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tok_push),
    .tok_i  (tok),
    .full_o (full),
    .pop_i  (tok_pop),
    .head_o (head)
  );

  nalsp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .tok_pop_o    (tok_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_byte_o   (out_byte_o),
    .unit_first_o (unit_first_o),
    .unit_last_o  (unit_last_o),
    .unit_kind_o  (unit_kind_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the H.264 start-code NAL unit splitter.
module tb_top;
  import nalsp_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 150;
  localparam int RandBytes     = 95;

  // how a directed row is checked
  typedef enum logic [1:0] {
    ChkModel,   // predictor decides
    ChkNone,    // row yields no words
    ChkUnit     // one-byte unit at chunk end: prefix plus this byte
  } chk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    chk_e       chk;
    logic [1:0] kind;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [1:0] kind;
  } nal_word_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       chunk_end = 1'b0;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       unit_first;
  logic       unit_last;
  logic [1:0] unit_kind;

  h264_start_code_nal_splitter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte),
    .chunk_end_i  (chunk_end),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte),
    .unit_first_o (unit_first),
    .unit_last_o  (unit_last),
    .unit_kind_o  (unit_kind)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // splitter state as predicted
  scan_mode_e sc_mode;
  logic [7:0] sc_win [2];
  int         sc_win_cnt;
  logic [7:0] sc_held [3];
  int         sc_held_cnt;
  logic [1:0] sc_kind;

  nal_word_t  step_words [$];
  nal_word_t  pending_words [$];

  int  errors     = 0;
  int  n_in       = 0;
  int  n_rand     = 0;
  int  n_chunks   = 0;
  int  n_out      = 0;
  int  n_units    = 0;
  int  idle_count = 0;
  bit  rx_hold_req = 1'b0;

  task automatic splitter_clear();
    sc_mode     = ScanSearch;
    sc_win[0]   = 8'h00;
    sc_win[1]   = 8'h00;
    sc_win_cnt  = 0;
    sc_held_cnt = 0;
    sc_kind     = KindSps;
  endtask

  task automatic shift_win(input logic [7:0] b);
    sc_win[0] = sc_win[1];
    sc_win[1] = b;
    if (sc_win_cnt < 2) sc_win_cnt++;
  endtask

  task automatic emit_word(input logic [7:0] b, input logic f, input logic l);
    nal_word_t w;
    w.data  = b;
    w.first = f;
    w.last  = l;
    w.kind  = sc_kind;
    step_words.push_back(w);
  endtask

  // Advance the predicted splitter by one input byte; words land in step_words.
  task automatic split_byte(input logic [7:0] b, input logic e);
    logic       hit;
    logic       known;
    logic [1:0] k;
    int         i;
    step_words.delete();
    hit = (sc_win_cnt >= 2) && (sc_win[0] == 8'h00) && (sc_win[1] == 8'h00) &&
          (b == StartCodeTail);
    case (sc_mode)
      ScanSearch, ScanSkip: begin
        if (hit) begin
          sc_mode    = ScanKind;
          sc_win_cnt = 0;
        end else begin
          shift_win(b);
        end
      end
      ScanKind: begin
        shift_win(b);
        known = 1'b1;
        k     = KindSps;
        case (b)
          NalSps:  k = KindSps;
          NalPps:  k = KindPps;
          NalIdr:  k = KindIdr;
          NalP:    k = KindP;
          default: known = 1'b0;
        endcase
        if (known) begin
          sc_kind = k;
          emit_word(8'h00, 1'b1, 1'b0);
          emit_word(8'h00, 1'b0, 1'b0);
          emit_word(8'h00, 1'b0, 1'b0);
          emit_word(8'h01, 1'b0, 1'b0);
          if (e) begin
            emit_word(b, 1'b0, 1'b1);
          end else begin
            sc_held[0]  = b;
            sc_held_cnt = 1;
            sc_mode     = ScanBody;
          end
        end else begin
          sc_mode = ScanSkip;
        end
      end
      default: begin
        if (hit) begin
          // held is the final byte followed by the two code zeros
          if (sc_held_cnt >= 3) emit_word(sc_held[0], 1'b0, 1'b1);
          sc_held_cnt = 0;
          sc_win_cnt  = 0;
          sc_mode     = ScanKind;
        end else if (e) begin
          for (i = 0; i < sc_held_cnt; i++) emit_word(sc_held[i], 1'b0, 1'b0);
          emit_word(b, 1'b0, 1'b1);
          sc_held_cnt = 0;
        end else begin
          if (sc_held_cnt >= 3) begin
            emit_word(sc_held[0], 1'b0, 1'b0);
            sc_held[0] = sc_held[1];
            sc_held[1] = sc_held[2];
            sc_held[2] = b;
          end else begin
            sc_held[sc_held_cnt] = b;
            sc_held_cnt++;
          end
          shift_win(b);
        end
      end
    endcase
    if (e) splitter_clear();
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic dir_row_t mk_row(input logic [7:0] b, input logic l, input chk_e c,
                                      input logic [1:0] k);
    dir_row_t row;
    row.data = b;
    row.last = l;
    row.chk  = c;
    row.kind = k;
    return row;
  endfunction

  // Offer one byte, hold it until taken, then queue what it should produce.
  task automatic send_word(input logic [7:0] b, input logic e, input chk_e chk,
                           input logic [1:0] k);
    nal_word_t w;
    push      <= 1'b1;
    in_byte   <= b;
    chunk_end <= e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_in++;
    split_byte(b, e);
    if (chk == ChkModel) begin
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    end else if (chk == ChkUnit) begin
      w = '{data: 8'h00, first: 1'b1, last: 1'b0, kind: k};
      pending_words.push_back(w);
      w.first = 1'b0;
      pending_words.push_back(w);
      pending_words.push_back(w);
      w.data = 8'h01;
      pending_words.push_back(w);
      w.data = b;
      w.last = 1'b1;
      pending_words.push_back(w);
    end
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Build one random chunk: mostly well-formed units, some junk and noise.
  task automatic send_chunk(input bit dense);
    logic [7:0] bytes_q [$];
    logic [7:0] hdr;
    int         units;
    int         blen;
    int         r;
    bit         calm;
    calm = ($urandom_range(0, 3) == 0);
    if (!dense && $urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 8)) bytes_q.push_back(body_byte());
    end else begin
      if (!dense && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) bytes_q.push_back(body_byte());
      end
      units = dense ? 3 : $urandom_range(1, 3);
      repeat (units) begin
        if ($urandom_range(0, 3) == 0) bytes_q.push_back(8'h00);
        bytes_q.push_back(8'h00);
        bytes_q.push_back(8'h00);
        bytes_q.push_back(StartCodeTail);
        r = $urandom_range(0, 11);
        case ($urandom_range(0, 3))
          0:       hdr = NalSps;
          1:       hdr = NalPps;
          2:       hdr = NalIdr;
          default: hdr = NalP;
        endcase
        if (dense || r < 8) bytes_q.push_back(hdr);
        else if (r == 8) bytes_q.push_back(8'h00);
        else if (r == 9) bytes_q.push_back(8'($urandom_range(0, 255)));
        // otherwise leave the unit empty
        if (dense) blen = $urandom_range(4, 8);
        else blen = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        repeat (blen) bytes_q.push_back(body_byte());
      end
    end
    foreach (bytes_q[i]) begin
      send_word(bytes_q[i], i == bytes_q.size() - 1, ChkModel, KindSps);
      n_rand++;
      idle_gap(calm ? 0 : gap_len());
    end
    n_chunks++;
  endtask

  task automatic check_word();
    nal_word_t want;
    n_out++;
    if (unit_first) n_units++;
    if (pending_words.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected word: byte %02h first %b last %b kind %0d",
                 out_byte, unit_first, unit_last, unit_kind);
      end
    end else begin
      want = pending_words.pop_front();
      if (out_byte !== want.data || unit_first !== want.first ||
          unit_last !== want.last || unit_kind !== want.kind) begin
        errors++;
        if (errors <= 10) begin
          $display("word %0d mismatch: exp byte %02h first %b last %b kind %0d",
                   n_out, want.data, want.first, want.last, want.kind);
          $display("             got byte %02h first %b last %b kind %0d",
                   out_byte, unit_first, unit_last, unit_kind);
        end
      end
    end
  endtask

  // result side: check popped words, stall at random, honor the long hold
  initial begin : result_side
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_word();
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 39) == 0) calm = 60;
        else stall = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_count = 0;
    else idle_count++;
    if (idle_count >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles, %0d still expected",
               idle_count, pending_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row_q [$];
    int       ci;
    // junk, start code, one-byte SPS unit closed by chunk end
    row_q.push_back(mk_row(8'hFF, 1'b0, ChkNone,  KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkNone,  KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkNone,  KindSps));
    row_q.push_back(mk_row(8'h01, 1'b0, ChkNone,  KindSps));
    row_q.push_back(mk_row(8'h67, 1'b1, ChkUnit,  KindSps));
    // PPS unit ended by a 4-byte code, then IDR unit ended by chunk end
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h01, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h68, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h01, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h65, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'hFF, 1'b1, ChkModel, KindSps));
    // P unit, then a start code as the last bytes of the chunk
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h01, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h61, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h01, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h00, 1'b0, ChkModel, KindSps));
    row_q.push_back(mk_row(8'h01, 1'b1, ChkModel, KindSps));
    // partial code at chunk end is no start code
    row_q.push_back(mk_row(8'h00, 1'b0, ChkNone,  KindSps));
    row_q.push_back(mk_row(8'h01, 1'b1, ChkNone,  KindSps));

    splitter_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (row_q[i]) begin
      send_word(row_q[i].data, row_q[i].last, row_q[i].chk, row_q[i].kind);
      idle_gap(gap_len());
    end
    idle_gap(1);
    wait_drained();

    ci = 0;
    while (n_rand < RandBytes) begin
      if (ci == 2) begin
        // hold off until the block has drained
        idle_gap(1);
        wait_drained();
      end
      if (ci == 0) rx_hold_req = 1'b1;
      send_chunk(ci == 0 || ci == 1);
      ci++;
    end

    idle_gap(1);
    wait_drained();
    repeat (20) @(posedge clk_i);
    errors += pending_words.size();

    $display("Fed %0d bytes: the directed table plus %0d random chunks (%0d bytes)",
             n_in, n_chunks, n_rand);
    $display("Checked %0d output words across %0d re-framed units", n_out, n_units);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
